// File: src/dq_pkg.sv
`default_nettype none

package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCNT_W = 5;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_DUMP_FWD   = 3'd4;
    localparam cmd_t CMD_DUMP_REV   = 3'd5;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

    // one write port, one read port on the entry memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// File: src/dq_cmd_if.sv
`default_nettype none

interface dq_cmd_if;
    import dq_pkg::*;

    logic                    valid;
    logic                    ready;
    cmd_t                    command;
    logic signed [VAL_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

`default_nettype wire

// File: src/dq_rsp_if.sv
`default_nettype none

interface dq_rsp_if;
    import dq_pkg::*;

    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic signed [VAL_W-1:0] element_value;
    logic signed [VAL_W-1:0] head_value;
    logic signed [VAL_W-1:0] tail_value;
    logic [OCNT_W-1:0]       entry_count;
    logic                    last_of_run;

    modport source (output valid, output status, output element_value, output head_value,
                    output tail_value, output entry_count, output last_of_run, input ready);
    modport sink   (input valid, input status, input element_value, input head_value,
                    input tail_value, input entry_count, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: src/dq_store.sv
`default_nettype none

module dq_store (
    input  wire logic                           clk,
    input  wire dq_pkg::mem_req_t               mem_req,
    output logic signed [dq_pkg::VAL_W-1:0]     mem_rdata
);
    import dq_pkg::*;

    logic [VAL_W-1:0] entry_mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            entry_mem[mem_req.waddr] <= mem_req.wdata;
        end
        // read data holds while no read is issued
        if (mem_req.re)
        begin
            rdata_reg <= entry_mem[mem_req.raddr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/dq_ctrl.sv
`default_nettype none

module dq_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dq_cmd_if.sink                              cmd,
    dq_rsp_if.source                            rsp,
    output dq_pkg::mem_req_t                    mem_req,
    input  wire logic signed [dq_pkg::VAL_W-1:0] mem_rdata
);
    import dq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POPW = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    localparam logic [ADDR_W:0]   DEPTH_A  = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
    localparam logic [CW-1:0]     CNT_FULL = CW'(DEPTH);

    // circular add, both operands below DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_A)
        begin
            s = s - DEPTH_A;
        end
        return s[ADDR_W-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       front_reg, front_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [VAL_W-1:0] head_reg, head_next;
    logic signed [VAL_W-1:0] tail_reg, tail_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    pend_last_reg, pend_last_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    dump_fwd_reg, dump_fwd_next;
    logic                    pop_front_reg, pop_front_next;
    logic signed [VAL_W-1:0] pop_elem_reg, pop_elem_next;

    logic                    ov_reg;
    status_t                 o_status_reg;
    logic signed [VAL_W-1:0] o_elem_reg;
    logic signed [VAL_W-1:0] o_head_reg;
    logic signed [VAL_W-1:0] o_tail_reg;
    logic [OCNT_W-1:0]       o_count_reg;
    logic                    o_last_reg;

    logic                    load;
    status_t                 ld_status;
    logic signed [VAL_W-1:0] ld_elem;
    logic signed [VAL_W-1:0] ld_head;
    logic signed [VAL_W-1:0] ld_tail;
    logic [CW-1:0]           ld_count;
    logic                    ld_last;

    logic out_free;
    logic in_ready;
    logic acc;
    logic is_empty;
    logic is_full;

    assign out_free = !ov_reg || rsp.ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign acc      = cmd.valid && in_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rd_pend_next   = rd_pend_reg;
        pend_last_next = pend_last_reg;
        idx_next       = idx_reg;
        dump_fwd_next  = dump_fwd_reg;
        pop_front_next = pop_front_reg;
        pop_elem_next  = pop_elem_reg;
        mem_req        = '0;
        load           = 1'b0;
        ld_status      = STAT_OK;
        ld_elem        = '0;
        ld_head        = head_reg;
        ld_tail        = tail_reg;
        ld_count       = count_reg;
        ld_last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (cmd.command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            load = 1'b1;
                            if (is_full)
                            begin
                                ld_status = STAT_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.wdata = cmd.push_value;
                                if (cmd.command == CMD_PUSH_FRONT)
                                begin
                                    front_next    = (front_reg == '0) ? LAST_A
                                                                      : front_reg - 1'b1;
                                    mem_req.waddr = front_next;
                                    head_next     = cmd.push_value;
                                    if (is_empty)
                                    begin
                                        tail_next = cmd.push_value;
                                    end
                                end
                                else
                                begin
                                    mem_req.waddr = wrap_add(front_reg, ADDR_W'(count_reg));
                                    tail_next     = cmd.push_value;
                                    if (is_empty)
                                    begin
                                        head_next = cmd.push_value;
                                    end
                                end
                                count_next = count_reg + 1'b1;
                                ld_head    = head_next;
                                ld_tail    = tail_next;
                                ld_count   = count_next;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_EMPTY;
                            end
                            else
                            begin
                                pop_front_next = (cmd.command == CMD_POP_FRONT);
                                pop_elem_next  = pop_front_next ? head_reg : tail_reg;
                                count_next     = count_reg - 1'b1;
                                if (pop_front_next)
                                begin
                                    front_next = wrap_add(front_reg, ADDR_W'(1));
                                end
                                if (count_reg == CW'(1))
                                begin
                                    // queue drains: ends read as zero
                                    load      = 1'b1;
                                    ld_elem   = pop_elem_next;
                                    head_next = '0;
                                    tail_next = '0;
                                    ld_head   = '0;
                                    ld_tail   = '0;
                                    ld_count  = '0;
                                end
                                else
                                begin
                                    // fetch the new end entry
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = pop_front_next
                                        ? wrap_add(front_reg, ADDR_W'(1))
                                        : wrap_add(front_reg, ADDR_W'(count_reg - CW'(2)));
                                    rd_pend_next  = 1'b1;
                                    state_next    = ST_POPW;
                                end
                            end
                        end
                        CMD_DUMP_FWD, CMD_DUMP_REV:
                        begin
                            if (is_empty)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next      = '0;
                                rd_pend_next  = 1'b0;
                                dump_fwd_next = (cmd.command == CMD_DUMP_FWD);
                                state_next    = ST_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POPW:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    ld_elem      = pop_elem_reg;
                    rd_pend_next = 1'b0;
                    state_next   = ST_IDLE;
                    if (pop_front_reg)
                    begin
                        head_next = mem_rdata;
                        ld_head   = mem_rdata;
                    end
                    else
                    begin
                        tail_next = mem_rdata;
                        ld_tail   = mem_rdata;
                    end
                end
            end
            ST_DUMP:
            begin
                if (rd_pend_reg && out_free)
                begin
                    load         = 1'b1;
                    ld_elem      = mem_rdata;
                    ld_last      = pend_last_reg;
                    rd_pend_next = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                // next read goes out once the pending beat is sure to leave
                if ((idx_reg != count_reg) && (!rd_pend_reg || out_free))
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = wrap_add(front_reg, dump_fwd_reg
                                        ? ADDR_W'(idx_reg)
                                        : ADDR_W'(count_reg - CW'(1) - idx_reg));
                    rd_pend_next   = 1'b1;
                    pend_last_next = (idx_reg == count_reg - CW'(1));
                    idx_next       = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
            idx_reg       <= '0;
            dump_fwd_reg  <= 1'b0;
            pop_front_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rd_pend_reg   <= rd_pend_next;
            pend_last_reg <= pend_last_next;
            idx_reg       <= idx_next;
            dump_fwd_reg  <= dump_fwd_next;
            pop_front_reg <= pop_front_next;
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pop_elem_reg <= pop_elem_next;
        if (load)
        begin
            o_status_reg <= ld_status;
            o_elem_reg   <= ld_elem;
            o_head_reg   <= ld_head;
            o_tail_reg   <= ld_tail;
            o_count_reg  <= OCNT_W'(ld_count);
            o_last_reg   <= ld_last;
        end
    end

    assign cmd.ready         = in_ready;
    assign rsp.valid         = ov_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.element_value = o_elem_reg;
    assign rsp.head_value    = o_head_reg;
    assign rsp.tail_value    = o_tail_reg;
    assign rsp.entry_count   = o_count_reg;
    assign rsp.last_of_run   = o_last_reg;

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
// channel | dir | handshake     | payload
// cmd     | in  | valid / ready | command, push_value
// rsp     | out | valid / ready | status, element_value, head_value, tail_value,
//         |     |               | entry_count, last_of_run
//
// Push, refused push, pop of the only entry and any request on an empty queue: answered from idle, no memory read.
// Pop with entries left: one memory read (state ST_POPW) to fetch the new front or back.
// Dump of N entries: one beat per cycle off the memory read port while the result side is not stalled.
// Reset clears front index, count and control; the entry memory needs no clearing.
// A command is taken while idle if the result register is empty or being drained.
`default_nettype none

module double_ended_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    dq_cmd_if.sink    cmd,
    dq_rsp_if.source  rsp
);
    import dq_pkg::*;

    mem_req_t                mem_req;
    logic signed [VAL_W-1:0] mem_rdata;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    dq_store u_store (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write issued together");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_FULL) |-> (rsp.entry_count == OCNT_W'(DEPTH)))
        else $error("full status with queue not full");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_EMPTY) |->
            (rsp.entry_count == '0 && rsp.head_value == '0 && rsp.tail_value == '0
             && rsp.last_of_run))
        else $error("empty status with stale contents");

    a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |-> (!rsp.valid || rsp.ready))
        else $error("command taken while result register blocked");

endmodule

`default_nettype wire

// File: tb/tb_double_ended_queue.sv
`timescale 1ns / 100ps

module tb_double_ended_queue;
    import dq_pkg::*;

    localparam cmd_t CMD_UNUSED_6 = 3'd6;
    localparam cmd_t CMD_UNUSED_7 = 3'd7;
    localparam int   MAX_WAIT     = 18;
    localparam int   RANDOM_ITEMS = 125;
    localparam int   DIR_ROWS     = 25;

    typedef struct {
        status_t           status;
        logic [VAL_W-1:0]  element_value;
        logic [VAL_W-1:0]  head_value;
        logic [VAL_W-1:0]  tail_value;
        logic [OCNT_W-1:0] entry_count;
        logic              last_of_run;
    } rsp_beat_t;

    typedef struct {
        cmd_t             command;
        logic [VAL_W-1:0] value;
        bit               typed;
        rsp_beat_t        known;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dq_cmd_if cmd_ch();
    dq_rsp_if rsp_ch();

    double_ended_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the queue
    logic [VAL_W-1:0] dq_store [DEPTH];
    int               dq_front;
    int               dq_count;

    rsp_beat_t step_beats  [$];
    rsp_beat_t pending_rsp [$];
    stim_row_t dir_rows [DIR_ROWS];

    int mismatches = 0;
    int rcv_stall  = 0;
    bit rcv_burst  = 1'b0;
    bit snd_burst  = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rsp_beat_t known_result(status_t st, logic [VAL_W-1:0] elem,
                                               logic [VAL_W-1:0] head,
                                               logic [VAL_W-1:0] tail, int n);
        rsp_beat_t b;
        b.status        = st;
        b.element_value = elem;
        b.head_value    = head;
        b.tail_value    = tail;
        b.entry_count   = OCNT_W'(n);
        b.last_of_run   = 1'b1;
        return b;
    endfunction

    function automatic rsp_beat_t snapshot(status_t st, logic [VAL_W-1:0] elem, logic last);
        rsp_beat_t b;
        b.status        = st;
        b.element_value = elem;
        b.head_value    = (dq_count != 0) ? dq_store[dq_front] : '0;
        b.tail_value    = (dq_count != 0) ? dq_store[(dq_front + dq_count - 1) % DEPTH] : '0;
        b.entry_count   = OCNT_W'(dq_count);
        b.last_of_run   = last;
        return b;
    endfunction

    // applies one command to the shadow queue, leaves its beats in step_beats
    function automatic void apply_command(cmd_t c, logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] removed;
        int               off;
        step_beats.delete();
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (dq_count >= DEPTH)
                begin
                    step_beats.push_back(snapshot(STAT_FULL, '0, 1'b1));
                end
                else
                begin
                    if (c == CMD_PUSH_FRONT)
                    begin
                        dq_front = (dq_front + DEPTH - 1) % DEPTH;
                        dq_store[dq_front] = v;
                    end
                    else
                    begin
                        dq_store[(dq_front + dq_count) % DEPTH] = v;
                    end
                    dq_count++;
                    step_beats.push_back(snapshot(STAT_OK, '0, 1'b1));
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (dq_count == 0)
                begin
                    step_beats.push_back(snapshot(STAT_EMPTY, '0, 1'b1));
                end
                else
                begin
                    if (c == CMD_POP_FRONT)
                    begin
                        removed  = dq_store[dq_front];
                        dq_front = (dq_front + 1) % DEPTH;
                    end
                    else
                    begin
                        removed = dq_store[(dq_front + dq_count - 1) % DEPTH];
                    end
                    dq_count--;
                    step_beats.push_back(snapshot(STAT_OK, removed, 1'b1));
                end
            end
            CMD_DUMP_FWD, CMD_DUMP_REV:
            begin
                if (dq_count == 0)
                begin
                    step_beats.push_back(snapshot(STAT_EMPTY, '0, 1'b1));
                end
                else
                begin
                    for (int i = 0; i < dq_count; i++)
                    begin
                        off = (c == CMD_DUMP_FWD) ? i : dq_count - 1 - i;
                        step_beats.push_back(snapshot(STAT_OK,
                                             dq_store[(dq_front + off) % DEPTH],
                                             i == dq_count - 1));
                    end
                end
            end
            default:
            begin
                // codes 6 and 7 are dropped by the block
            end
        endcase
    endfunction

    // drives one command beat; returns at the edge where it is taken
    task automatic issue(cmd_t c, logic [VAL_W-1:0] v, bit typed, rsp_beat_t known,
                         bit drain_first);
        int gap;
        gap = snd_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 9) == 0)
            snd_burst = !snd_burst;
        @(negedge clk);
        if (gap > 0 || drain_first)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
            while (drain_first && pending_rsp.size() != 0)
                @(negedge clk);
            if (gap > 1)
                repeat (gap - 1) @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c;
        cmd_ch.push_value <= v;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        apply_command(c, v);
        if (typed)
        begin
            pending_rsp.push_back(known);
        end
        else
        begin
            foreach (step_beats[i])
                pending_rsp.push_back(step_beats[i]);
        end
    endtask

    // result side: sample at the rising edge
    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result beat: status %0d element %h count %0d",
                       rsp_ch.status, rsp_ch.element_value, rsp_ch.entry_count);
                mismatches++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.element_value !== want.element_value)
                begin
                    $error("element_value: expected %h, got %h",
                           want.element_value, rsp_ch.element_value);
                    mismatches++;
                end
                if (rsp_ch.head_value !== want.head_value)
                begin
                    $error("head_value: expected %h, got %h",
                           want.head_value, rsp_ch.head_value);
                    mismatches++;
                end
                if (rsp_ch.tail_value !== want.tail_value)
                begin
                    $error("tail_value: expected %h, got %h",
                           want.tail_value, rsp_ch.tail_value);
                    mismatches++;
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp_ch.entry_count);
                    mismatches++;
                end
                if (rsp_ch.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, rsp_ch.last_of_run);
                    mismatches++;
                end
            end
            rcv_stall = rcv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 11) == 0)
                rcv_burst = !rcv_burst;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (rcv_stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rcv_stall--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL double_ended_queue");
        $finish;
    end

    initial
    begin
        cmd_t             c;
        logic [VAL_W-1:0] v;
        int               r;
        int               legal_sent;
        bit               fill_phase;

        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_PUSH_FRONT;
        cmd_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        dq_front          = 0;
        dq_count          = 0;

        dir_rows = '{
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, known_result(STAT_EMPTY, 0, 0, 0, 0)},
            '{CMD_DUMP_REV,   32'h0000_0000, 1'b1, known_result(STAT_EMPTY, 0, 0, 0, 0)},
            '{CMD_UNUSED_6,   32'hffff_ffff, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_UNUSED_7,   32'h1234_5678, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b1,
              known_result(STAT_OK, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1)},
            '{CMD_PUSH_BACK,  32'h8000_0000, 1'b1,
              known_result(STAT_OK, 0, 32'h7fff_ffff, 32'h8000_0000, 2)},
            '{CMD_PUSH_FRONT, 32'hffff_ffff, 1'b1,
              known_result(STAT_OK, 0, 32'hffff_ffff, 32'h8000_0000, 3)},
            '{CMD_PUSH_BACK,  32'h0000_0000, 1'b1,
              known_result(STAT_OK, 0, 32'hffff_ffff, 32'h0000_0000, 4)},
            '{CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_BACK,  32'haaaa_aaaa, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_BACK,  32'hffff_fffe, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_FRONT, 32'h1234_5678, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_BACK,  32'h8765_4321, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_FRONT, 32'h0f0f_0f0f, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_BACK,  32'hf0f0_f0f0, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_FRONT, 32'h00ff_00ff, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_BACK,  32'hff00_ff00, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_FRONT, 32'h7fff_fffe, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_PUSH_BACK,  32'h8000_0001, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            // queue is full here: push refused, nothing moves
            '{CMD_PUSH_FRONT, 32'hdead_beef, 1'b1,
              known_result(STAT_FULL, 0, 32'h7fff_fffe, 32'h8000_0001, DEPTH)},
            '{CMD_DUMP_FWD,   32'h0000_0000, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_DUMP_REV,   32'h0000_0000, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)},
            '{CMD_POP_BACK,   32'h0000_0000, 1'b0, known_result(STAT_OK, 0, 0, 0, 0)}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].command, dir_rows[i].value, dir_rows[i].typed,
                  dir_rows[i].known, 1'b0);

        // random part: alternate fill-biased and drain-biased stretches so both
        // the full and the empty boundary are hit repeatedly
        legal_sent = 0;
        while (legal_sent < RANDOM_ITEMS)
        begin
            fill_phase = ((legal_sent / 20) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < 3)
                c = $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
            else if (r < 13)
                c = $urandom_range(0, 1) ? CMD_DUMP_REV : CMD_DUMP_FWD;
            else if (r < (fill_phase ? 78 : 35))
                c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else
                c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;

            case ($urandom_range(0, 15))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'hffff_ffff;
                3:       v = 32'h0000_0000;
                default: v = $urandom();
            endcase

            issue(c, v, 1'b0, known_result(STAT_OK, 0, 0, 0, 0),
                  legal_sent % 40 == 39);
            if (c != CMD_UNUSED_6 && c != CMD_UNUSED_7)
                legal_sent++;
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end

endmodule
